// ----- rtl/svgpx_pkg.sv -----
// ----------------------------------------------------------------------------
// svgpx_pkg
// shared types and constants of the svg width/height pt-to-px rewriter
// ----------------------------------------------------------------------------
package svgpx_pkg;

  // keyword text, first character in the low byte
  localparam logic [47:0] KW_SVG    = {24'h0, "gvs"};
  localparam logic [47:0] KW_WIDTH  = {8'h0, "htdiw"};
  localparam logic [47:0] KW_HEIGHT = "thgieh";

  localparam logic [2:0] KW_SVG_LEN    = 3'd3;
  localparam logic [2:0] KW_WIDTH_LEN  = 3'd5;
  localparam logic [2:0] KW_HEIGHT_LEN = 3'd6;

  localparam logic [7:0] CH_P  = "p";
  localparam logic [7:0] CH_T  = "t";
  localparam logic [7:0] CH_X  = "x";
  localparam logic [7:0] CH_LT = "<";
  localparam logic [7:0] CH_GT = ">";
  localparam logic [7:0] CH_EQ = "=";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       doc_start;
  } svgpx_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       rewritten;
    logic       all_done;
  } svgpx_result_t;

endpackage

// ----- rtl/svgpx_parser.sv -----
// ----------------------------------------------------------------------------
// svgpx_parser
// tag/attribute state machine with incremental keyword match and rewrite
// ----------------------------------------------------------------------------
module svgpx_parser
  import svgpx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  svgpx_item_t   item,
  output svgpx_result_t result
);

  typedef enum logic [3:0] {
    PH_OUTSIDE   = 4'd0,
    PH_TAG_START = 4'd1,
    PH_TAG_NAME  = 4'd2,
    PH_TAG_WS    = 4'd3,
    PH_ATTR_NAME = 4'd4,
    PH_EQUALS    = 4'd5,
    PH_OPEN_Q    = 4'd6,
    PH_VALUE     = 4'd7,
    PH_CLOSE_Q   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_WIDTH   = 2'd1,
    KIND_HEIGHT  = 2'd2
  } kind_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic kw_ok(input logic [2:0] len, input logic [7:0] c,
                                 input logic [47:0] txt, input logic [2:0] klen);
    return (len < klen) && (txt[{len, 3'b000} +: 8] == c);
  endfunction

  phase_t     phase_r, phase_nxt, cur_phase;
  logic [7:0] quote_r, quote_nxt, cur_quote;
  logic [7:0] prev_r, prev_nxt, cur_prev;
  logic [2:0] len_r, len_nxt, cur_len;
  logic [2:0] match_r, match_nxt, cur_match;
  logic       svg_r, svg_nxt, cur_svg;
  kind_t      kind_r, kind_nxt, cur_kind;
  logic       wseen_r, wseen_nxt, cur_wseen;
  logic       hseen_r, hseen_nxt, cur_hseen;
  logic       done_r, done_nxt, cur_done;
  logic [7:0] c;
  logic [7:0] res;
  logic       rw;
  logic       name_clr;

  assign c = item.data_byte;

  // start of document clears everything before the byte is handled
  assign cur_phase = item.doc_start ? PH_OUTSIDE   : phase_r;
  assign cur_quote = item.doc_start ? 8'h00        : quote_r;
  assign cur_prev  = item.doc_start ? 8'h00        : prev_r;
  assign cur_len   = item.doc_start ? 3'd0         : len_r;
  assign cur_match = item.doc_start ? 3'b111       : match_r;
  assign cur_svg   = item.doc_start ? 1'b0         : svg_r;
  assign cur_kind  = item.doc_start ? KIND_UNKNOWN : kind_r;
  assign cur_wseen = item.doc_start ? 1'b0         : wseen_r;
  assign cur_hseen = item.doc_start ? 1'b0         : hseen_r;
  assign cur_done  = item.doc_start ? 1'b0         : done_r;

  always_comb begin
    phase_nxt = cur_phase;
    quote_nxt = cur_quote;
    prev_nxt  = cur_prev;
    len_nxt   = cur_len;
    match_nxt = cur_match;
    svg_nxt   = cur_svg;
    kind_nxt  = cur_kind;
    wseen_nxt = cur_wseen;
    hseen_nxt = cur_hseen;
    done_nxt  = cur_done;
    res       = c;
    rw        = 1'b0;
    name_clr  = 1'b0;
    if (!cur_done) begin
      unique case (cur_phase)
        PH_TAG_START: begin
          phase_nxt = PH_TAG_NAME;
        end
        PH_TAG_NAME: begin
          if (is_ws(c) || (c == CH_GT)) begin
            svg_nxt   = cur_match[0] && (cur_len == KW_SVG_LEN);
            name_clr  = 1'b1;
            phase_nxt = (c == CH_GT) ? PH_OUTSIDE : PH_TAG_WS;
          end
        end
        PH_TAG_WS: begin
          if (c == CH_GT) begin
            phase_nxt = PH_OUTSIDE;
          end else if (!is_ws(c)) begin
            phase_nxt = PH_ATTR_NAME;
          end
        end
        PH_ATTR_NAME: begin
          if (c == CH_EQ) begin
            if (cur_match[1] && (cur_len == KW_WIDTH_LEN)) begin
              kind_nxt = KIND_WIDTH;
            end else if (cur_match[2] && (cur_len == KW_HEIGHT_LEN)) begin
              kind_nxt = KIND_HEIGHT;
            end else begin
              kind_nxt = KIND_UNKNOWN;
            end
            name_clr  = 1'b1;
            phase_nxt = PH_EQUALS;
          end
        end
        PH_EQUALS: begin
          quote_nxt = c;
          phase_nxt = PH_OPEN_Q;
        end
        PH_OPEN_Q: begin
          phase_nxt = PH_VALUE;
        end
        PH_VALUE: begin
          if (((cur_kind == KIND_WIDTH) || (cur_kind == KIND_HEIGHT)) && cur_svg &&
              (cur_prev == CH_P) && (c == CH_T)) begin
            res = CH_X;
            rw  = 1'b1;
            if (cur_kind == KIND_WIDTH) begin
              wseen_nxt = 1'b1;
            end else begin
              hseen_nxt = 1'b1;
            end
            done_nxt = wseen_nxt && hseen_nxt;
          end else if (c == cur_quote) begin
            phase_nxt = PH_CLOSE_Q;
            name_clr  = 1'b1;
          end
        end
        PH_CLOSE_Q: begin
          phase_nxt = (c == CH_GT) ? PH_OUTSIDE : PH_TAG_WS;
        end
        default: begin
          phase_nxt = (c == CH_LT) ? PH_TAG_START : PH_OUTSIDE;
        end
      endcase
      if (name_clr) begin
        len_nxt   = 3'd0;
        match_nxt = 3'b111;
      end
      if ((phase_nxt == PH_TAG_NAME) || (phase_nxt == PH_ATTR_NAME)) begin
        match_nxt[0] = match_nxt[0] && kw_ok(len_nxt, c, KW_SVG, KW_SVG_LEN);
        match_nxt[1] = match_nxt[1] && kw_ok(len_nxt, c, KW_WIDTH, KW_WIDTH_LEN);
        match_nxt[2] = match_nxt[2] && kw_ok(len_nxt, c, KW_HEIGHT, KW_HEIGHT_LEN);
        len_nxt      = (len_nxt == 3'd7) ? 3'd7 : len_nxt + 3'd1;
      end
      prev_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTSIDE;
      quote_r <= 8'h00;
      prev_r  <= 8'h00;
      len_r   <= 3'd0;
      match_r <= 3'b111;
      svg_r   <= 1'b0;
      kind_r  <= KIND_UNKNOWN;
      wseen_r <= 1'b0;
      hseen_r <= 1'b0;
      done_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      quote_r <= quote_nxt;
      prev_r  <= prev_nxt;
      len_r   <= len_nxt;
      match_r <= match_nxt;
      svg_r   <= svg_nxt;
      kind_r  <= kind_nxt;
      wseen_r <= wseen_nxt;
      hseen_r <= hseen_nxt;
      done_r  <= done_nxt;
    end
  end

  assign result.out_byte  = res;
  assign result.rewritten = rw;
  assign result.all_done  = done_nxt;

  a_done_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (wseen_r && hseen_r))
    else $error("finished without both attributes rewritten");

  a_rw_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && rw) |-> (cur_phase == PH_VALUE && cur_svg))
    else $error("rewrite outside an svg attribute value");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && done_r && !item.doc_start) |=> ($stable(phase_r) && $stable(prev_r)))
    else $error("state moved after finish");

endmodule

// ----- rtl/svg_pt_to_px_rewriter_unit.sv -----
// ----------------------------------------------------------------------------
// svg_pt_to_px_rewriter_unit
// streaming rewrite of pt to px in width/height of svg tags
// ----------------------------------------------------------------------------
//  channel | ports      | tdata          | tuser                          | tlast
//  input   | in_*       | data_byte[7:0] | doc_start                      | chunk_last
//  result  | out_*      | out_byte[7:0]  | rewritten, all_done (low first) | chunk_last_out
//
//  one byte per cycle sustained while out_tready stays high; path: input register, then result register
//  the parser state updates as a byte moves from the input to the result register
//  rst_n is synchronous, active low; it empties both registers and clears the parser
//  out_tready low holds the result; a byte is still taken while the input register is free
// ----------------------------------------------------------------------------
module svg_pt_to_px_rewriter_unit
  import svgpx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic [0:0] in_tuser,   // doc_start
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [1:0] out_tuser,  // rewritten, all_done
  output logic       out_tlast
);

  logic          in_valid_r;
  svgpx_item_t   in_item_r;
  logic          in_last_r;
  logic          out_valid_r;
  svgpx_result_t out_res_r;
  logic          out_last_r;
  logic          out_free;
  logic          advance;
  logic          in_take;
  svgpx_result_t res;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  svgpx_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.data_byte <= in_tdata;
      in_item_r.doc_start <= in_tuser[0];
      in_last_r           <= in_tlast;
    end
    if (advance) begin
      out_res_r  <= res;
      out_last_r <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.out_byte;
  assign out_tuser  = {out_res_r.all_done, out_res_r.rewritten};
  assign out_tlast  = out_last_r;

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("result lost after advance");

  a_rw_is_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == CH_X))
    else $error("rewritten byte is not x");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |=> (in_valid_r && $stable(in_item_r) && $stable(in_last_r)))
    else $error("stalled input register changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// ----- verif/svg_pt_to_px_rewriter_unit_test.sv -----
// ----------------------------------------------------------------------------
// svg_pt_to_px_rewriter_unit_test
// Self-checking bench for the streaming pt-to-px rewriter. Markup documents
// with random content are streamed one beat at a time: svg and other tags,
// width/height and decoy attributes, odd quote characters and values full of
// p/t pairs, plus broken documents and raw noise. A scoreboard class tracks
// the tag/attribute parser on its own and checks every result beat in order,
// with random idle bursts on both sides of the stream.
// ----------------------------------------------------------------------------
module svg_pt_to_px_rewriter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import svgpx_pkg::*;

  localparam int TOTAL_BYTES    = 800;
  localparam int QUIET_FROM     = 680;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SLASH = "/";

  typedef enum logic [3:0] {
    PH_OUTSIDE, PH_TAG_START, PH_TAG_NAME, PH_TAG_WS, PH_ATTR_NAME,
    PH_EQUALS, PH_OPEN_Q, PH_VALUE, PH_CLOSE_Q
  } phase_e;

  typedef enum logic [1:0] {KIND_NONE, KIND_WIDTH, KIND_HEIGHT} kind_e;

  typedef enum int {KEY_SVG, KEY_WIDTH, KEY_HEIGHT} key_e;

  typedef struct {
    svgpx_result_t res;
    logic          last;
  } out_beat_t;

  class svg_rewrite_scoreboard;
    phase_e      phase;
    kind_e       kind;
    logic [7:0]  quote_ch;
    logic [7:0]  prev_ch;
    logic [2:0]  name_len;
    logic [2:0]  key_hits;
    logic        svg_tag;
    logic        width_hit;
    logic        height_hit;
    logic        frozen;
    logic [47:0] key_text [3];
    logic [2:0]  key_len [3];
    out_beat_t   expected_q [$];
    int          mismatches;
    int          results_seen;
    int          rewrites_due;
    int          frozen_due;

    function new();
      key_text = '{KW_SVG, KW_WIDTH, KW_HEIGHT};
      key_len  = '{KW_SVG_LEN, KW_WIDTH_LEN, KW_HEIGHT_LEN};
      clear_parser();
    endfunction

    function void clear_parser();
      phase      = PH_OUTSIDE;
      kind       = KIND_NONE;
      quote_ch   = '0;
      prev_ch    = '0;
      svg_tag    = 1'b0;
      width_hit  = 1'b0;
      height_hit = 1'b0;
      frozen     = 1'b0;
      name_reset();
    endfunction

    function void name_reset();
      name_len = '0;
      key_hits = '1;
    endfunction

    function void name_push(logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
        if (name_len >= key_len[k]) begin
          key_hits[k] = 1'b0;
        end else if (key_text[k][8*name_len +: 8] != c) begin
          key_hits[k] = 1'b0;
        end
      end
      if (name_len != 3'd7) begin
        name_len = name_len + 3'd1;
      end
    endfunction

    function logic name_is(key_e k);
      return key_hits[k] && (name_len == key_len[k]);
    endfunction

    function logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // advance the parser by one accepted input beat and queue its result
    function void take_input(logic [7:0] c, logic start, logic last);
      out_beat_t e;
      if (start) begin
        clear_parser();
      end
      e.res.out_byte  = c;
      e.res.rewritten = 1'b0;
      e.last          = last;
      if (!frozen) begin
        case (phase)
          PH_TAG_START: begin
            phase = PH_TAG_NAME;
          end
          PH_TAG_NAME: begin
            if (is_space(c) || c == CH_GT) begin
              svg_tag = name_is(KEY_SVG);
              name_reset();
              phase = (c == CH_GT) ? PH_OUTSIDE : PH_TAG_WS;
            end
          end
          PH_TAG_WS: begin
            if (c == CH_GT) begin
              phase = PH_OUTSIDE;
            end else if (!is_space(c)) begin
              phase = PH_ATTR_NAME;
            end
          end
          PH_ATTR_NAME: begin
            if (c == CH_EQ) begin
              if (name_is(KEY_WIDTH)) begin
                kind = KIND_WIDTH;
              end else if (name_is(KEY_HEIGHT)) begin
                kind = KIND_HEIGHT;
              end else begin
                kind = KIND_NONE;
              end
              name_reset();
              phase = PH_EQUALS;
            end
          end
          PH_EQUALS: begin
            quote_ch = c;
            phase = PH_OPEN_Q;
          end
          PH_OPEN_Q: begin
            phase = PH_VALUE;
          end
          PH_VALUE: begin
            if ((kind == KIND_WIDTH || kind == KIND_HEIGHT) && svg_tag &&
                prev_ch == CH_P && c == CH_T) begin
              e.res.out_byte  = CH_X;
              e.res.rewritten = 1'b1;
              if (kind == KIND_WIDTH) begin
                width_hit = 1'b1;
              end else begin
                height_hit = 1'b1;
              end
              frozen = width_hit && height_hit;
            end else if (c == quote_ch) begin
              phase = PH_CLOSE_Q;
              name_reset();
            end
          end
          PH_CLOSE_Q: begin
            phase = (c == CH_GT) ? PH_OUTSIDE : PH_TAG_WS;
          end
          default: begin
            phase = (c == CH_LT) ? PH_TAG_START : PH_OUTSIDE;
          end
        endcase
        if (phase == PH_TAG_NAME || phase == PH_ATTR_NAME) begin
          name_push(c);
        end
        prev_ch = e.res.out_byte;
      end
      e.res.all_done = frozen;
      rewrites_due += e.res.rewritten;
      frozen_due   += e.res.all_done;
      expected_q.push_back(e);
    endfunction

    function void check_output(logic [7:0] b, logic [1:0] u, logic last);
      out_beat_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result beat %0d: byte %02h user %b last %b",
                   results_seen, b, u, last);
        end
        return;
      end
      e = expected_q.pop_front();
      if (b !== e.res.out_byte || u[0] !== e.res.rewritten ||
          u[1] !== e.res.all_done || last !== e.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch at result %0d: expected byte %02h rw %b done %b last %b, got byte %02h rw %b done %b last %b",
                   results_seen, e.res.out_byte, e.res.rewritten, e.res.all_done,
                   e.last, b, u[0], u[1], last);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // data_byte
  logic [0:0] in_tuser;   // doc_start
  logic       in_tlast;   // chunk_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // out_byte
  logic [1:0] out_tuser;  // rewritten, all_done
  logic       out_tlast;  // chunk_last_out

  svg_rewrite_scoreboard sb = new();

  logic [7:0] doc_bytes [$];
  int         bytes_sent;
  int         docs_sent;
  int         noise_docs;
  int         in_idle_odds;
  int         out_idle_odds;
  int         stall_left;
  int         idle_cycles;
  logic       quiet;

  svg_pt_to_px_rewriter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0 && !quiet) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && out_idle_odds != 0 &&
                 $urandom_range(0, out_idle_odds - 1) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // beat monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.take_input(in_tdata, in_tuser[0], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        sb.check_output(out_tdata, out_tuser, out_tlast);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic start, input logic last);
    if (!quiet && in_idle_odds != 0 && $urandom_range(0, in_idle_odds - 1) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= start;
    in_tlast    <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (bytes_sent >= QUIET_FROM) begin
      quiet = 1'b1;
    end
  endtask

  task automatic send_doc(input logic first_start);
    int n;
    logic start;
    logic last;
    n = doc_bytes.size();
    for (int i = 0; i < n; i++) begin
      start = (i == 0) ? first_start : ($urandom_range(0, 99) == 0);
      last  = (i == n - 1) || ($urandom_range(0, 15) == 0);
      push_beat(doc_bytes[i], start, last);
    end
    doc_bytes.delete();
    docs_sent++;
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      doc_bytes.push_back(s[i]);
    end
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 7))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_CR;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_ch();
    case ($urandom_range(0, 4))
      0: return CH_P;
      1: return CH_T;
      2: return 8'd48 + 8'($urandom_range(0, 9));
      default: return 8'd97 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic string pick_tag_name();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return "svg";
      5: return "sv";
      6: return "svgg";
      7: return "rect";
      8: return "SVG";
      default: return "g";
    endcase
  endfunction

  function automatic string pick_attr_name();
    case ($urandom_range(0, 10))
      0, 1, 2: return "width";
      3, 4, 5: return "height";
      6: return "widths";
      7: return "heigh";
      8: return "heightwidth";
      9: return "x";
      default: return "viewBox";
    endcase
  endfunction

  function automatic void add_value();
    logic [7:0] q;
    case ($urandom_range(0, 5))
      0, 1, 2: q = CH_DQ;
      3, 4: q = CH_SQ;
      default: q = pick_text_ch();
    endcase
    doc_bytes.push_back(CH_EQ);
    doc_bytes.push_back(q);
    doc_bytes.push_back(8'd48 + 8'($urandom_range(0, 9)));
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 6))
        0, 1: add_str("pt");
        2: add_str("px");
        3: add_str("ppt");
        4: add_str("p");
        5: add_str("t");
        default: doc_bytes.push_back(8'd48 + 8'($urandom_range(0, 9)));
      endcase
    end
    doc_bytes.push_back(q);
  endfunction

  function automatic void build_tag();
    doc_bytes.push_back(CH_LT);
    add_str(pick_tag_name());
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 2)) doc_bytes.push_back(pick_space());
      add_str(pick_attr_name());
      add_value();
    end
    if ($urandom_range(0, 2) == 0) begin
      doc_bytes.push_back(pick_space());
    end
    if ($urandom_range(0, 3) == 0) begin
      doc_bytes.push_back(CH_SLASH);
    end
    doc_bytes.push_back(CH_GT);
  endfunction

  function automatic void build_doc();
    int cut;
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 4)) doc_bytes.push_back(pick_text_ch());
      build_tag();
    end
    // broken documents: a stray byte or a cut-off end
    if ($urandom_range(0, 5) == 0) begin
      doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, doc_bytes.size() - 1);
      repeat (cut) void'(doc_bytes.pop_back());
    end
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(4, 30)) doc_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void pick_idle_mix();
    case ($urandom_range(0, 3))
      0: begin
        in_idle_odds  = 0;
        out_idle_odds = 0;
      end
      1: begin
        in_idle_odds  = 4;
        out_idle_odds = 16;
      end
      2: begin
        in_idle_odds  = 16;
        out_idle_odds = 4;
      end
      default: begin
        in_idle_odds  = 8;
        out_idle_odds = 8;
      end
    endcase
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    stall_left    = 0;
    idle_cycles   = 0;
    bytes_sent    = 0;
    docs_sent     = 0;
    noise_docs    = 0;
    quiet         = 1'b0;
    in_idle_odds  = 0;
    out_idle_odds = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme bytes, then both attributes rewritten and a byte after freeze
    push_beat(8'hFF, 1'b1, 1'b1);
    add_str("<svg width=qptq");
    doc_bytes.push_back(CH_TAB);
    add_str("height=qpt");
    doc_bytes.push_back(8'h00);
    for (int i = 0; i < doc_bytes.size(); i++) begin
      push_beat(doc_bytes[i], i == 0, i == doc_bytes.size() - 1);
    end
    doc_bytes.delete();
    docs_sent++;

    while (bytes_sent < TOTAL_BYTES) begin
      pick_idle_mix();
      if ($urandom_range(0, 3) == 0) begin
        build_noise();
        noise_docs++;
        send_doc(1'($urandom_range(0, 1)));
      end else begin
        build_doc();
        send_doc($urandom_range(0, 7) != 0);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("streamed %0d bytes in %0d documents (%0d of them noise), %0d results checked",
             bytes_sent, docs_sent, noise_docs, sb.results_seen);
    $display("%0d pt-to-px rewrites and %0d beats after both attributes were done, %0d mismatches",
             sb.rewrites_due, sb.frozen_due, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
